// ----- sv/twepa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package twepa_pkg;

  // Field widths
  localparam int RAW_W   = 12;
  localparam int POSE_W  = 16;
  localparam int POS_W   = 32;
  localparam int NUM_WHL = 3;

  // Default wheel counter width
  localparam int COUNTER_BITS_DEF = 12;

  // Preset arithmetic: Q16 coefficients, products and three-term sums
  localparam int Q16_SH = 16;
  localparam int PROD_W = 37;
  localparam int SUM_W  = 40;

  localparam logic signed [PROD_W-1:0] K_BIG   = PROD_W'(89522);
  localparam logic signed [PROD_W-1:0] K_SMALL = PROD_W'(23986);
  localparam logic signed [PROD_W-1:0] K_ROT   = PROD_W'(787186);

  // Opcodes and channel codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_PRESET = 1'b1;
  localparam logic [1:0] CH_INVALID = 2'd3;

  typedef logic signed [POSE_W-1:0] pose_t;
  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Divide by 2^16, truncating toward zero, keep low 32 bits
  function automatic pos_t q16_trunc(input sum_t s);
    sum_t adj;
    sum_t shf;
    adj = s + (s[SUM_W-1] ? SUM_W'(65535) : SUM_W'(0));
    shf = adj >>> Q16_SH;
    return shf[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/twepa_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface twepa_in_if import twepa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [1:0]       channel;
  logic [RAW_W-1:0] raw_count;
  pose_t            pose_x;
  pose_t            pose_y;
  pose_t            pose_theta;

  modport source (output valid, op, channel, raw_count, pose_x, pose_y, pose_theta,
                  input ready);
  modport sink   (input valid, op, channel, raw_count, pose_x, pose_y, pose_theta,
                  output ready);
endinterface

interface twepa_out_if import twepa_pkg::*; ();
  logic valid;
  logic ready;
  pos_t position;

  modport source (output valid, position, input ready);
  modport sink   (input valid, position, output ready);
endinterface

`default_nettype wire

// ----- sv/three_wheel_encoder_position_accumulator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A sample word is held in the input register once accepted, then loaded into the result
//   register when the output can take it; a preset updates the positions in the cycle after acceptance.
// Throughput: one word per cycle while the output is not stalled, set by the single update stage
//   behind the input register; the preset multiplies by constants on the way into that register.
// Reset (synchronous, rst_n low): all positions and last counter readings cleared to 0.
module three_wheel_encoder_position_accumulator import twepa_pkg::*; #(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  twepa_in_if.sink    in_s,
  twepa_out_if.source out_s
);

  localparam int RAW_KEEP = (COUNTER_BITS < RAW_W) ? COUNTER_BITS : RAW_W;
  localparam int CB       = COUNTER_BITS;

  // Input stage registers
  logic          s1_valid_r;
  logic          s1_op_r;
  logic [1:0]    s1_ch_r;
  logic [CB-1:0] s1_raw_r;
  prod_t         s1_xb_r, s1_xs_r, s1_yb_r, s1_ys_r, s1_tr_r;
  pose_t         s1_x_r, s1_y_r;

  // Wheel state
  logic [CB-1:0] last_raw_r [NUM_WHL];
  pos_t          pos_r      [NUM_WHL];

  // Result register
  logic out_valid_r;
  pos_t out_pos_r;

  logic s1_adv;
  logic s1_ch_ok;

  // Handshake: a preset leaves no result, so it never waits on the output side
  assign s1_adv    = s1_valid_r && (s1_op_r == OP_PRESET || !out_valid_r || out_s.ready);
  assign in_s.ready = !s1_valid_r || s1_adv;
  assign s1_ch_ok  = (s1_ch_r != CH_INVALID);

  assign out_s.valid    = out_valid_r;
  assign out_s.position = out_pos_r;

  // Input register: capture word, constant products for a preset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      s1_valid_r <= in_s.valid;
    end
    if (in_s.ready && in_s.valid) begin
      s1_op_r  <= in_s.op;
      s1_ch_r  <= in_s.channel;
      s1_raw_r <= CB'(in_s.raw_count[RAW_KEEP-1:0]);
      s1_x_r   <= in_s.pose_x;
      s1_y_r   <= in_s.pose_y;
      s1_xb_r  <= PROD_W'(in_s.pose_x) * K_BIG;
      s1_xs_r  <= PROD_W'(in_s.pose_x) * K_SMALL;
      s1_yb_r  <= PROD_W'(in_s.pose_y) * K_BIG;
      s1_ys_r  <= PROD_W'(in_s.pose_y) * K_SMALL;
      s1_tr_r  <= PROD_W'(in_s.pose_theta) * K_ROT;
    end
  end

  // Sample path: wrapped counter delta, sign-extended, added to the chosen wheel
  logic [1:0]    ch_idx;
  logic [CB-1:0] delta;
  pos_t          delta_ext;
  pos_t          pos_new;

  assign ch_idx    = s1_ch_ok ? s1_ch_r : 2'd0;
  assign delta     = s1_raw_r - last_raw_r[ch_idx];
  assign delta_ext = {{(POS_W-CB){delta[CB-1]}}, delta};
  assign pos_new   = pos_r[ch_idx] + delta_ext;

  // Preset path: three-term sums, truncated toward zero
  sum_t sum0, sum1, sum2;

  always_comb begin
    sum0 = -SUM_W'(s1_xb_r) - SUM_W'(s1_ys_r) - SUM_W'(s1_tr_r);
    sum1 = (SUM_W'(s1_x_r) <<< Q16_SH) - (SUM_W'(s1_y_r) <<< Q16_SH) - SUM_W'(s1_tr_r);
    sum2 = SUM_W'(s1_xs_r) + SUM_W'(s1_yb_r) - SUM_W'(s1_tr_r);
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_WHL; i++) begin
        last_raw_r[i] <= '0;
        pos_r[i]      <= '0;
      end
    end else if (s1_adv) begin
      if (s1_op_r == OP_PRESET) begin
        pos_r[0] <= q16_trunc(sum0);
        pos_r[1] <= q16_trunc(sum1);
        pos_r[2] <= q16_trunc(sum2);
      end else if (s1_ch_ok) begin
        last_raw_r[ch_idx] <= s1_raw_r;
        pos_r[ch_idx]      <= pos_new;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_op_r == OP_SAMPLE) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv && s1_op_r == OP_SAMPLE) begin
      out_pos_r <= s1_ch_ok ? pos_new : '0;
    end
  end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import twepa_pkg::*;

  localparam int    CYCLE_LIMIT  = 200000;
  localparam int    HOLD_CYCLES  = 200;
  localparam int    DRAIN_CYCLES = 8;
  localparam int    RANDOM_WORDS = 400;
  localparam int    NUM_DIRECTED = 25;
  localparam int    PAUSE_AT     = 200;
  localparam longint Q16_UNIT    = 65536;
  localparam longint COEF_MAJOR  = 89522;
  localparam longint COEF_MINOR  = 23986;
  localparam longint COEF_TURN   = 787186;

  // One directed word; want is used only where typed is set
  typedef struct packed {
    logic             op;
    logic [1:0]       channel;
    logic [RAW_W-1:0] raw;
    pose_t            px;
    pose_t            py;
    pose_t            pt;
    logic             typed;
    pos_t             want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  twepa_in_if  in_s ();
  twepa_out_if out_s ();

  three_wheel_encoder_position_accumulator dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_s),
    .out_s(out_s)
  );

  // Shadow state of the wheels
  pos_t             wheel_pos  [0:NUM_WHL-1];
  logic [RAW_W-1:0] last_count [0:NUM_WHL-1];

  pos_t      expected_positions[$];
  stim_row_t directed [0:NUM_DIRECTED-1];

  int  cycle_count  = 0;
  int  error_count  = 0;
  int  words_in     = 0;
  int  words_out    = 0;
  int  presets_sent = 0;
  int  invalid_sent = 0;
  bit  calm         = 1'b0;
  bit  hold_done    = 1'b0;

  always #5 clk = ~clk;

  // Update the shadow wheels for one word; returns 1 when a result is due
  function automatic bit advance_wheels(input logic op, input logic [1:0] ch,
                                        input logic [RAW_W-1:0] raw,
                                        input pose_t x, input pose_t y, input pose_t t,
                                        output pos_t position);
    longint lx, ly, lt;
    logic [RAW_W-1:0] step;
    position = '0;
    if (op == OP_PRESET) begin
      lx = x;
      ly = y;
      lt = t;
      // Inverse kinematics, each sum divided with truncation toward zero
      wheel_pos[0] = pos_t'((-lx * COEF_MAJOR - ly * COEF_MINOR - lt * COEF_TURN) / Q16_UNIT);
      wheel_pos[1] = pos_t'((lx * Q16_UNIT - ly * Q16_UNIT - lt * COEF_TURN) / Q16_UNIT);
      wheel_pos[2] = pos_t'((lx * COEF_MINOR + ly * COEF_MAJOR - lt * COEF_TURN) / Q16_UNIT);
      return 1'b0;
    end
    if (ch == CH_INVALID) return 1'b1;
    // Wrapped counter delta, read as signed
    step = raw - last_count[ch];
    last_count[ch] = raw;
    wheel_pos[ch] = wheel_pos[ch] + {{(POS_W-RAW_W){step[RAW_W-1]}}, step};
    position = wheel_pos[ch];
    return 1'b1;
  endfunction

  // Mostly short gaps, a few long ones, none in a calm stretch
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pose_t random_pose();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return pose_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic note_mismatch(input string what, input pos_t want, input pos_t got);
    if (error_count < 10)
      $display("%0t: %s position: expected %0d, got %0d", $time, what, want, got);
    error_count++;
  endtask

  // Offer one word after a random gap and wait for it to be taken
  task automatic send_word(input logic op, input logic [1:0] ch, input logic [RAW_W-1:0] raw,
                           input pose_t x, input pose_t y, input pose_t t,
                           input logic typed, input pos_t want);
    int   gap;
    bit   has_result;
    pos_t position;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_s.valid <= 1'b0;
    end
    @(negedge clk);
    in_s.valid      <= 1'b1;
    in_s.op         <= op;
    in_s.channel    <= ch;
    in_s.raw_count  <= raw;
    in_s.pose_x     <= x;
    in_s.pose_y     <= y;
    in_s.pose_theta <= t;
    @(posedge clk);
    while (!in_s.ready) @(posedge clk);
    has_result = advance_wheels(op, ch, raw, x, y, t, position);
    if (has_result) expected_positions.push_back(typed ? want : position);
    words_in++;
    if (op == OP_PRESET) presets_sent++;
    else if (ch == CH_INVALID) invalid_sent++;
  endtask

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d positions outstanding",
               cycle_count, expected_positions.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result checker
  always @(posedge clk) begin
    pos_t want;
    if (rst_n && out_s.valid && out_s.ready) begin
      words_out++;
      if (expected_positions.size() == 0) begin
        note_mismatch("unexpected", '0, out_s.position);
      end else begin
        want = expected_positions.pop_front();
        if (out_s.position !== want) note_mismatch("wrong", want, out_s.position);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off while words keep coming
  initial begin
    int stall;
    stall = 0;
    out_s.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_out >= 100) begin
        hold_done = 1'b1;
        out_s.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        out_s.ready <= 1'b0;
        stall--;
      end else begin
        out_s.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    logic             op;
    logic [1:0]       ch;
    logic [RAW_W-1:0] raw;
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_s.valid      = 1'b0;
    in_s.op         = OP_SAMPLE;
    in_s.channel    = '0;
    in_s.raw_count  = '0;
    in_s.pose_x     = '0;
    in_s.pose_y     = '0;
    in_s.pose_theta = '0;
    for (int i = 0; i < NUM_WHL; i++) begin
      wheel_pos[i]  = '0;
      last_count[i] = '0;
    end

    // op, channel, raw, x, y, theta, typed, want
    directed[0]  = '{OP_SAMPLE, 2'd0, 12'd0,    16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 32'sd0};
    directed[1]  = '{OP_SAMPLE, 2'd1, 12'd4095, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, -32'sd1};
    directed[2]  = '{OP_SAMPLE, 2'd2, 12'd2047, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 32'sd2047};
    // exactly half the counter range counts backward
    directed[3]  = '{OP_SAMPLE, 2'd0, 12'd2048, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, -32'sd2048};
    directed[4]  = '{OP_SAMPLE, CH_INVALID, 12'd4095, 16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b1, 32'sd0};
    directed[5]  = '{OP_SAMPLE, CH_INVALID, 12'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 32'sd0};
    // zero pose clears positions, last readings stay
    directed[6]  = '{OP_PRESET, 2'd0, 12'd0,    16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[7]  = '{OP_SAMPLE, 2'd0, 12'd2048, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 32'sd0};
    directed[8]  = '{OP_SAMPLE, 2'd1, 12'd4095, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 32'sd0};
    directed[9]  = '{OP_SAMPLE, 2'd2, 12'd2047, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 32'sd0};
    // extreme poses, with the sample fields ignored
    directed[10] = '{OP_PRESET, CH_INVALID, 12'd4095, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0, 32'sd0};
    directed[11] = '{OP_SAMPLE, 2'd0, 12'd2048, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[12] = '{OP_SAMPLE, 2'd1, 12'd0,    16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[13] = '{OP_SAMPLE, 2'd2, 12'd4095, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[14] = '{OP_PRESET, 2'd0, 12'd0,    16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 32'sd0};
    directed[15] = '{OP_SAMPLE, 2'd0, 12'd2048, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[16] = '{OP_SAMPLE, 2'd1, 12'd2048, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[17] = '{OP_SAMPLE, 2'd2, 12'd0,    16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    // small poses where truncation toward zero matters
    directed[18] = '{OP_PRESET, 2'd1, 12'd7,    16'sh0001, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[19] = '{OP_SAMPLE, 2'd0, 12'd2048, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[20] = '{OP_SAMPLE, 2'd1, 12'd2048, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[21] = '{OP_SAMPLE, 2'd2, 12'd0,    16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[22] = '{OP_PRESET, 2'd2, 12'd0,    16'sh0000, 16'sh0000, 16'shFFFF, 1'b0, 32'sd0};
    directed[23] = '{OP_SAMPLE, 2'd2, 12'd1,    16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};
    directed[24] = '{OP_SAMPLE, 2'd1, 12'd2047, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 32'sd0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_word(directed[i].op, directed[i].channel, directed[i].raw, directed[i].px,
                directed[i].py, directed[i].pt, directed[i].typed, directed[i].want);

    // Random words, mostly small moves, some half-range jumps and presets
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == PAUSE_AT) begin
        // sender waits for the block to drain completely
        @(negedge clk);
        in_s.valid <= 1'b0;
        while (expected_positions.size() != 0) @(posedge clk);
      end
      calm = (n >= 300 && n < 360);
      op = ($urandom_range(0, 99) < 6) ? OP_PRESET : OP_SAMPLE;
      ch = ($urandom_range(0, 9) == 0) ? CH_INVALID : 2'($urandom_range(0, 2));
      if (ch == CH_INVALID) begin
        raw = RAW_W'($urandom_range(0, 4095));
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: raw = last_count[ch] + RAW_W'($urandom_range(0, 80)) - RAW_W'(40);
          5, 6:          raw = last_count[ch] + RAW_W'(2047 + $urandom_range(0, 2));
          default:       raw = RAW_W'($urandom_range(0, 4095));
        endcase
      end
      send_word(op, ch, raw, random_pose(), random_pose(), random_pose(), 1'b0, '0);
    end
    calm = 1'b0;
    @(negedge clk);
    in_s.valid <= 1'b0;

    // Drain and report
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words: %0d presets, %0d invalid-channel samples; checked %0d positions",
             words_in, presets_sent, invalid_sent, words_out);
    $display("Long output hold-off and full drain pause exercised; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/twepa_pkg.sv
sv/twepa_in_if.sv
sv/three_wheel_encoder_position_accumulator.sv
sim/testbench.sv
